// ===== hw/rtl/bvbw_pkg.sv =====
// ----------------------------------------------------------------------------
// bvbw_pkg
// shared types and constants of the box volume blend weight core
// ----------------------------------------------------------------------------
package bvbw_pkg;

  localparam int unsigned COORD_W  = 32;
  localparam int unsigned RAD_W    = 31;
  localparam int unsigned GAIN_W   = 17;
  localparam int unsigned WGT_W    = 17;
  localparam int unsigned D2_W     = 64;
  localparam int unsigned ROOT_W   = 32;
  localparam int unsigned REM_W    = 36;
  localparam int unsigned QUO_W    = 16;
  localparam int unsigned PROD_W   = WGT_W + GAIN_W;
  localparam int unsigned SQRT_STG = 16;
  localparam int unsigned DIV_STG  = 8;
  localparam int unsigned IDX_W    = 3;

  localparam logic [WGT_W-1:0]  WGT_ONE  = WGT_W'(1) << 16;
  localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << 15;

  typedef enum logic [IDX_W-1:0] {
    REG_MIN_X  = 3'd0,
    REG_MIN_Y  = 3'd1,
    REG_MIN_Z  = 3'd2,
    REG_MAX_X  = 3'd3,
    REG_MAX_Y  = 3'd4,
    REG_MAX_Z  = 3'd5,
    REG_RADIUS = 3'd6,
    REG_GAIN   = 3'd7
  } bvbw_reg_e;

  // flags that ride along with each word through the pipeline
  typedef struct packed {
    logic in_vol;
    logic sat;
  } bvbw_side_t;

endpackage

// ===== hw/rtl/bvbw_if.sv =====
// ----------------------------------------------------------------------------
// bvbw channel interfaces
// point input, weight output and register write channels
// ----------------------------------------------------------------------------
interface bvbw_point_if;
  import bvbw_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [COORD_W-1:0] point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface bvbw_blend_if;
  import bvbw_pkg::*;
  logic             valid;
  logic             ready;
  logic [WGT_W-1:0] blend_out;
  logic             inside_flag;
  modport source (output valid, blend_out, inside_flag, input ready);
  modport sink   (input valid, blend_out, inside_flag, output ready);
endinterface

interface bvbw_cfg_if;
  import bvbw_pkg::*;
  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   index;
  logic [COORD_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/bvbw_isqrt.sv =====
// ----------------------------------------------------------------------------
// bvbw_isqrt
// pipelined integer square root, two result bits per stage
// ----------------------------------------------------------------------------
module bvbw_isqrt
  import bvbw_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [D2_W-1:0]   rad_i,
  input  bvbw_side_t        side_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o,
  output bvbw_side_t        side_o
);

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  function automatic sq_t sq_step(sq_t cur, logic [1:0] pr);
    sq_t              nxt;
    logic [REM_W-1:0] r2;
    logic [REM_W-1:0] trial;
    r2    = {cur.rem[REM_W-3:0], pr};
    trial = {2'b00, cur.root, 2'b01};
    if (r2 >= trial) begin
      nxt.rem  = r2 - trial;
      nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
    end else begin
      nxt.rem  = r2;
      nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
    end
    return nxt;
  endfunction

  logic       [SQRT_STG-1:0]            vld_q;
  sq_t        [SQRT_STG-1:0]            st_q;
  logic       [SQRT_STG-1:0][D2_W-1:0]  rad_q;
  bvbw_side_t [SQRT_STG-1:0]            side_q;

  for (genvar s = 0; s < SQRT_STG; s++) begin : g_stg
    logic              src_v;
    sq_t               src_st;
    logic [D2_W-1:0]   src_rad;
    bvbw_side_t        src_side;
    sq_t               mid, fin;

    if (s == 0) begin : g_first
      assign src_v    = valid_i;
      assign src_st   = '0;
      assign src_rad  = rad_i;
      assign src_side = side_i;
    end else begin : g_next
      assign src_v    = vld_q[s-1];
      assign src_st   = st_q[s-1];
      assign src_rad  = rad_q[s-1];
      assign src_side = side_q[s-1];
    end

    assign mid = sq_step(src_st, src_rad[D2_W-1 -: 2]);
    assign fin = sq_step(mid, src_rad[D2_W-3 -: 2]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[s]   <= fin;
        rad_q[s]  <= {src_rad[D2_W-5:0], 4'b0000};
        side_q[s] <= src_side;
      end
    end
  end

  assign valid_o = vld_q[SQRT_STG-1];
  assign root_o  = st_q[SQRT_STG-1].root;
  assign side_o  = side_q[SQRT_STG-1];

endmodule

// ===== hw/rtl/bvbw_div.sv =====
// ----------------------------------------------------------------------------
// bvbw_div
// pipelined restoring divider for the distance to radius ratio
// ----------------------------------------------------------------------------
module bvbw_div
  import bvbw_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [RAD_W-1:0] radius_i,
  input  logic             valid_i,
  input  logic [RAD_W-1:0] dist_i,
  input  bvbw_side_t       side_i,
  output logic             valid_o,
  output logic [QUO_W-1:0] quo_o,
  output bvbw_side_t       side_o
);

  typedef struct packed {
    logic [RAD_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } dv_t;

  function automatic dv_t dv_step(dv_t cur, logic [RAD_W-1:0] den);
    dv_t            nxt;
    logic [RAD_W:0] r2;
    r2 = {cur.rem, 1'b0};
    if (r2 >= {1'b0, den}) begin
      r2      = r2 - {1'b0, den};
      nxt.quo = {cur.quo[QUO_W-2:0], 1'b1};
    end else begin
      nxt.quo = {cur.quo[QUO_W-2:0], 1'b0};
    end
    nxt.rem = r2[RAD_W-1:0];
    return nxt;
  endfunction

  logic       [DIV_STG-1:0] vld_q;
  dv_t        [DIV_STG-1:0] st_q;
  bvbw_side_t [DIV_STG-1:0] side_q;

  for (genvar s = 0; s < DIV_STG; s++) begin : g_stg
    logic       src_v;
    dv_t        src_st;
    bvbw_side_t src_side;
    dv_t        mid, fin;

    if (s == 0) begin : g_first
      assign src_v      = valid_i;
      assign src_st.rem = dist_i;
      assign src_st.quo = '0;
      assign src_side   = side_i;
    end else begin : g_next
      assign src_v    = vld_q[s-1];
      assign src_st   = st_q[s-1];
      assign src_side = side_q[s-1];
    end

    assign mid = dv_step(src_st, radius_i);
    assign fin = dv_step(mid, radius_i);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[s]   <= fin;
        side_q[s] <= src_side;
      end
    end
  end

  assign valid_o = vld_q[DIV_STG-1];
  assign quo_o   = st_q[DIV_STG-1].quo;
  assign side_o  = side_q[DIV_STG-1];

endmodule

// ===== hw/rtl/box_volume_blend_weight_core.sv =====
// ----------------------------------------------------------------------------
// box_volume_blend_weight_core
// blend weight of an axis-aligned box volume for a stream of 3d points
// ----------------------------------------------------------------------------
// channels: point_i takes one word per point (x, y, z in q16.16), blend_o
// gives one word per point (weight in q1.16, 65536 = 1.0, and inside flag),
// cfg_i writes the box corners, falloff radius and gain by register index.
// cfg_i is always ready; write it only while no point is in flight.
// throughput: one point per cycle while blend_o is not stalled; the pipeline is
// 30 register stages deep (excess, squares, sum, 16 square root stages, compare,
// 8 divider stages, gain multiply, output register).
// stall: the whole pipeline advances together; when blend_o holds a word that
// is not taken, every stage holds and point_i drops ready. empty stages do
// not stall anything by themselves.
// reset: all stage valid bits and the configuration registers clear to zero.
// ----------------------------------------------------------------------------
module box_volume_blend_weight_core
  import bvbw_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  bvbw_point_if.sink      point_i,
  bvbw_cfg_if.sink        cfg_i,
  bvbw_blend_if.source    blend_o
);

  // configuration registers
  logic signed [COORD_W-1:0] min_q [3];
  logic signed [COORD_W-1:0] max_q [3];
  logic        [RAD_W-1:0]   radius_q;
  logic        [GAIN_W-1:0]  gain_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        min_q[a] <= '0;
        max_q[a] <= '0;
      end
      radius_q <= '0;
      gain_q   <= '0;
    end else if (cfg_i.valid) begin
      unique case (bvbw_reg_e'(cfg_i.index))
        REG_MIN_X:  min_q[0] <= cfg_i.data;
        REG_MIN_Y:  min_q[1] <= cfg_i.data;
        REG_MIN_Z:  min_q[2] <= cfg_i.data;
        REG_MAX_X:  max_q[0] <= cfg_i.data;
        REG_MAX_Y:  max_q[1] <= cfg_i.data;
        REG_MAX_Z:  max_q[2] <= cfg_i.data;
        REG_RADIUS: radius_q <= cfg_i.data[RAD_W-1:0];
        REG_GAIN:   gain_q   <= cfg_i.data[GAIN_W-1:0];
        default:    ;
      endcase
    end
  end

  // global advance: everything moves unless the output word is stuck
  logic out_v_q;
  logic en;
  assign en            = !out_v_q || blend_o.ready;
  assign point_i.ready = en;

  // stage 1: per-axis excess outside the box, corners put in order
  logic signed [COORD_W-1:0] pt [3];
  logic [COORD_W-1:0]        ex_d [3];
  logic [2:0]                in_ax;
  assign pt[0] = point_i.point_x;
  assign pt[1] = point_i.point_y;
  assign pt[2] = point_i.point_z;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic signed [COORD_W-1:0] lo, hi;
      logic signed [COORD_W:0]   df;
      lo = (min_q[a] > max_q[a]) ? max_q[a] : min_q[a];
      hi = (min_q[a] > max_q[a]) ? min_q[a] : max_q[a];
      if (pt[a] < lo) begin
        df        = {lo[COORD_W-1], lo} - {pt[a][COORD_W-1], pt[a]};
        in_ax[a]  = 1'b0;
      end else if (pt[a] > hi) begin
        df        = {pt[a][COORD_W-1], pt[a]} - {hi[COORD_W-1], hi};
        in_ax[a]  = 1'b0;
      end else begin
        df        = '0;
        in_ax[a]  = 1'b1;
      end
      ex_d[a] = df[COORD_W-1:0];
    end
  end

  logic               v1_q, v2_q, v3_q;
  logic [COORD_W-1:0] ex_q [3];
  logic               in1_q, in2_q, in3_q;
  logic [D2_W-1:0]    sq_q [3];
  logic [D2_W-1:0]    d2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= point_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // stage 2: squares; stage 3: saturating sum of squares
  logic [D2_W+1:0] sum;
  assign sum = {2'b00, sq_q[0]} + {2'b00, sq_q[1]} + {2'b00, sq_q[2]};

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        ex_q[a] <= ex_d[a];
        sq_q[a] <= D2_W'(ex_q[a]) * D2_W'(ex_q[a]);
      end
      in1_q <= &in_ax;
      in2_q <= in1_q;
      in3_q <= in2_q;
      d2_q  <= (sum[D2_W+1:D2_W] != 2'b00) ? '1 : sum[D2_W-1:0];
    end
  end

  // square root
  bvbw_side_t        sq_side_in, sq_side;
  logic              sq_v;
  logic [ROOT_W-1:0] root;
  assign sq_side_in.in_vol = in3_q;
  assign sq_side_in.sat    = 1'b0;

  bvbw_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .rad_i   (d2_q),
    .side_i  (sq_side_in),
    .valid_o (sq_v),
    .root_o  (root),
    .side_o  (sq_side)
  );

  // compare stage: distance at or beyond radius means zero falloff
  logic             vc_q;
  logic [RAD_W-1:0] dist_q;
  bvbw_side_t       cmp_side_q;
  logic             far;
  assign far = root >= {1'b0, radius_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (en) begin
      vc_q <= sq_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_q            <= far ? '0 : root[RAD_W-1:0];
      cmp_side_q.in_vol <= sq_side.in_vol;
      cmp_side_q.sat    <= far;
    end
  end

  // ratio = dist * 65536 / radius
  logic             dv_v;
  logic [QUO_W-1:0] quo;
  bvbw_side_t       dv_side;

  bvbw_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .radius_i (radius_q),
    .valid_i  (vc_q),
    .dist_i   (dist_q),
    .side_i   (cmp_side_q),
    .valid_o  (dv_v),
    .quo_o    (quo),
    .side_o   (dv_side)
  );

  // gain multiply stage
  logic              vm_q;
  logic [PROD_W-1:0] prod_q;
  logic              inm_q;
  logic [WGT_W-1:0]  t;
  assign t = dv_side.sat ? '0 : (WGT_ONE - {1'b0, quo});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else if (en) begin
      vm_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= PROD_W'(t) * PROD_W'(gain_q);
      inm_q  <= dv_side.in_vol;
    end
  end

  // output stage: round half up, clamp, inside and disabled overrides
  logic [PROD_W-1:0] rnd;
  logic [WGT_W-1:0]  w;
  logic [WGT_W-1:0]  blend_d;
  assign rnd = (prod_q + RND_HALF) >> 16;
  assign w   = (rnd > PROD_W'(WGT_ONE)) ? WGT_ONE : rnd[WGT_W-1:0];

  always_comb begin
    priority if (inm_q) begin
      blend_d = WGT_ONE;
    end else if (radius_q == '0 || gain_q == '0) begin
      blend_d = '0;
    end else begin
      blend_d = w;
    end
  end

  logic [WGT_W-1:0] blend_q;
  logic             inside_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      blend_q  <= blend_d;
      inside_q <= inm_q;
    end
  end

  assign blend_o.valid       = out_v_q;
  assign blend_o.blend_out   = blend_q;
  assign blend_o.inside_flag = inside_q;

  // inside points always carry full weight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && inside_q |-> blend_q == WGT_ONE)
    else $error("inside point without full weight");

  // weight never exceeds one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> blend_q <= WGT_ONE)
    else $error("weight above one");

  // a stalled pipeline keeps its first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> v1_q == $past(v1_q))
    else $error("first stage moved during stall");

  // an accepted point reaches the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    point_i.valid && en |=> v1_q)
    else $error("accepted point lost");

endmodule
